@@ design/v86e_pkg.sv @@
// Shared types and constants for the virtual-8086 sensitive instruction emulator.
// No dependencies; every other design file imports this package.
package v86e_pkg;

    localparam logic [7:0] OPC_OPSIZE   = 8'h66;
    localparam logic [7:0] OPC_ADDRSIZE = 8'h67;
    localparam logic [7:0] OPC_PUSHF    = 8'h9C;
    localparam logic [7:0] OPC_POPF     = 8'h9D;
    localparam logic [7:0] OPC_INT      = 8'hCD;
    localparam logic [7:0] OPC_IRET     = 8'hCF;
    localparam logic [7:0] OPC_STI      = 8'hFB;
    localparam logic [7:0] OPC_CLI      = 8'hFA;

    localparam logic [3:0]  MAX_PREFIXES = 4'd14;
    localparam logic [31:0] VM_IF_BITS   = 32'h0002_0200;
    localparam logic [31:0] KEEP_FLAGS   = 32'h0000_0DFF;

    localparam int unsigned IN_DATA_W  = 216;
    localparam int unsigned OUT_DATA_W = 200;

    typedef enum logic [2:0] {
        KIND_PUSHF,
        KIND_POPF,
        KIND_INT,
        KIND_IRET,
        KIND_STI,
        KIND_CLI,
        KIND_ILLEGAL
    } t_kind;

    // One trapped instruction byte with its machine context.
    typedef struct packed {
        logic [7:0]  code_byte;
        logic [31:0] vector_entry;
        logic [15:0] stack_word0;
        logic [15:0] stack_word1;
        logic [15:0] stack_word2;
        logic [15:0] code_segment;
        logic [31:0] instr_pointer;
        logic [15:0] stack_segment;
        logic [31:0] stack_pointer;
        logic [31:0] flags_in;
    } t_item;

    // Classified instruction handed from the front end to the back end.
    typedef struct packed {
        t_kind       kind;
        logic        wide;
        logic [31:0] next_ip;
        logic [31:0] stack_base;
        logic [31:0] vector_entry;
        logic [15:0] stack_word0;
        logic [15:0] stack_word1;
        logic [15:0] stack_word2;
        logic [15:0] code_segment;
        logic [31:0] instr_pointer;
        logic [31:0] stack_pointer;
        logic [31:0] flags_in;
    } t_work;

    typedef struct packed {
        logic        status;
        logic [15:0] new_code_segment;
        logic [31:0] new_instr_pointer;
        logic [31:0] new_flags;
        logic [31:0] new_stack_pointer;
        logic [31:0] write_address;
        logic [47:0] write_data;
        logic [2:0]  write_bytes;
    } t_result;

endpackage

@@ design/v86e_front.sv @@
// Front end: accepts code bytes, tracks prefix state and classifies instructions.
// Depends on v86e_pkg.
module v86e_front
    import v86e_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_push,
    output t_work o_work,
    input  logic  i_full
);

    logic       r_wide;
    logic [3:0] r_prefix_count;
    logic       n_wide;
    logic [3:0] n_prefix_count;
    logic       accept;
    logic       is_prefix;
    logic       absorb;

    assign o_ready   = !i_full;
    assign accept    = i_valid && !i_full;
    assign is_prefix = i_item.code_byte inside {OPC_OPSIZE, OPC_ADDRSIZE};
    // A prefix below the limit is counted (66h sets wide); no transaction.
    assign absorb    = is_prefix && (r_prefix_count < MAX_PREFIXES);
    assign o_push    = accept && !absorb;

    always_comb begin
        n_wide         = r_wide;
        n_prefix_count = r_prefix_count;
        if (accept) begin
            if (absorb) begin
                n_prefix_count = r_prefix_count + 4'd1;
                if (i_item.code_byte == OPC_OPSIZE) begin
                    n_wide = 1'b1;
                end
            end else begin
                n_wide         = 1'b0;
                n_prefix_count = 4'd0;
            end
        end
    end

    always_comb begin
        o_work.wide          = r_wide;
        o_work.next_ip       = i_item.instr_pointer + {28'd0, r_prefix_count} + 32'd1;
        o_work.stack_base    = {12'd0, i_item.stack_segment, 4'd0} + i_item.stack_pointer;
        o_work.vector_entry  = i_item.vector_entry;
        o_work.stack_word0   = i_item.stack_word0;
        o_work.stack_word1   = i_item.stack_word1;
        o_work.stack_word2   = i_item.stack_word2;
        o_work.code_segment  = i_item.code_segment;
        o_work.instr_pointer = i_item.instr_pointer;
        o_work.stack_pointer = i_item.stack_pointer;
        o_work.flags_in      = i_item.flags_in;
        case (i_item.code_byte)
            OPC_PUSHF: o_work.kind = KIND_PUSHF;
            OPC_POPF:  o_work.kind = KIND_POPF;
            OPC_INT:   o_work.kind = KIND_INT;
            OPC_IRET:  o_work.kind = KIND_IRET;
            OPC_STI:   o_work.kind = KIND_STI;
            OPC_CLI:   o_work.kind = KIND_CLI;
            default:   o_work.kind = KIND_ILLEGAL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide         <= 1'b0;
            r_prefix_count <= 4'd0;
        end else begin
            r_wide         <= n_wide;
            r_prefix_count <= n_prefix_count;
        end
    end

endmodule

@@ design/v86e_fifo.sv @@
// Two-entry queue of classified instructions between front and back end.
// Depends on v86e_pkg.
module v86e_fifo
    import v86e_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_work o_work
);

    t_work      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_work  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/v86e_back.sv @@
// Back end: executes classified instructions, keeps the virtual IF and holds the result.
// Depends on v86e_pkg.
module v86e_back
    import v86e_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_work   i_work,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic        r_vif;
    logic        n_vif;
    logic        r_out_valid;
    t_result     r_result;
    t_result     n_result;
    logic [15:0] sp16;
    logic [15:0] step;
    logic [15:0] pushed_flags;

    assign o_pop    = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;
    assign sp16     = i_work.stack_pointer[15:0];
    assign step     = i_work.wide ? 16'd4 : 16'd2;
    assign pushed_flags = {i_work.flags_in[15:10], r_vif, i_work.flags_in[8:0]};

    always_comb begin
        n_vif                      = r_vif;
        n_result.status            = 1'b0;
        n_result.new_code_segment  = i_work.code_segment;
        n_result.new_instr_pointer = i_work.instr_pointer;
        n_result.new_flags         = i_work.flags_in;
        n_result.new_stack_pointer = i_work.stack_pointer;
        n_result.write_address     = 32'd0;
        n_result.write_data        = 48'd0;
        n_result.write_bytes       = 3'd0;
        case (i_work.kind)
            KIND_PUSHF: begin
                n_result.new_stack_pointer = {16'd0, sp16 - step};
                n_result.write_address     = i_work.stack_base - {16'd0, step};
                n_result.write_data        = {36'd0, pushed_flags[11:0]};
                n_result.write_bytes       = step[2:0];
                n_result.new_instr_pointer = i_work.next_ip;
            end
            KIND_POPF: begin
                n_result.new_flags = VM_IF_BITS |
                                     ({16'd0, i_work.stack_word0} & KEEP_FLAGS);
                n_vif = i_work.stack_word0[9];
                n_result.new_stack_pointer = {16'd0, sp16 + step};
                n_result.new_instr_pointer = i_work.next_ip;
            end
            KIND_INT: begin
                n_result.new_stack_pointer = {16'd0, sp16 - 16'd6};
                n_result.write_address     = i_work.stack_base - 32'd6;
                n_result.write_data        = {pushed_flags, i_work.code_segment,
                                              i_work.next_ip[15:0] + 16'd1};
                n_result.write_bytes       = 3'd6;
                n_result.new_code_segment  = i_work.vector_entry[31:16];
                n_result.new_instr_pointer = {16'd0, i_work.vector_entry[15:0]};
            end
            KIND_IRET: begin
                n_result.new_instr_pointer = {16'd0, i_work.stack_word0};
                n_result.new_code_segment  = i_work.stack_word1;
                n_result.new_flags         = {16'd0, i_work.stack_word2} | VM_IF_BITS;
                n_vif = i_work.stack_word2[9];
                n_result.new_stack_pointer = {16'd0, sp16 + 16'd6};
            end
            KIND_STI: begin
                n_vif = 1'b1;
                n_result.new_instr_pointer = i_work.next_ip;
            end
            KIND_CLI: begin
                n_vif = 1'b0;
                n_result.new_instr_pointer = i_work.next_ip;
            end
            default: begin
                n_result.status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vif       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_vif       <= n_vif;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ design/v86_sensitive_instruction_emulator_top.sv @@
// Top level of the virtual-8086 sensitive instruction emulator.
// Depends on v86e_pkg, v86e_front, v86e_fifo and v86e_back.
//
// Usage: the slave stream carries one trapped code byte per transaction together with
// the trapped CS, EIP, SS, ESP, EFLAGS, the three words at the stack top and the
// interrupt-table entry. Up to 14 operand and address size prefixes in a row are
// absorbed and produce no output transaction; every other byte, a further prefix
// too, produces exactly one master transaction with the new registers, the stack
// write to perform, and status in tuser (1 = illegal). The queue captures the
// classified byte at the accepting edge and the back end then loads it into the
// output register, which drives the master side. One byte is accepted every cycle
// while the receiver keeps up: the back end pops whenever its output is free or taken.
// When the receiver stalls, the output register holds its result and the queue fills;
// s_tready drops once both queue entries are occupied.
// Reset clears the virtual interrupt flag, the prefix state, the queue and the output valid flag.
module v86_sensitive_instruction_emulator_top
    import v86e_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // code_byte, vector_entry, stack_word0, stack_word1, stack_word2, code_segment,
    // instr_pointer, stack_segment, stack_pointer, flags_in
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // new_code_segment, new_instr_pointer, new_flags, new_stack_pointer,
    // write_address, write_data, write_bytes, zero padding
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status
    output logic                  m_tuser
);

    t_item   item;
    t_work   front_work;
    t_work   queue_work;
    t_result result;
    logic    push;
    logic    full;
    logic    queue_valid;
    logic    pop;

    assign item.code_byte     = s_tdata[7:0];
    assign item.vector_entry  = s_tdata[39:8];
    assign item.stack_word0   = s_tdata[55:40];
    assign item.stack_word1   = s_tdata[71:56];
    assign item.stack_word2   = s_tdata[87:72];
    assign item.code_segment  = s_tdata[103:88];
    assign item.instr_pointer = s_tdata[135:104];
    assign item.stack_segment = s_tdata[151:136];
    assign item.stack_pointer = s_tdata[183:152];
    assign item.flags_in      = s_tdata[215:184];

    v86e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_item  (item),
        .o_push  (push),
        .o_work  (front_work),
        .i_full  (full)
    );

    v86e_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_work  (queue_work)
    );

    v86e_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_valid),
        .i_work   (queue_work),
        .o_pop    (pop),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_result (result)
    );

    assign m_tuser = result.status;
    assign m_tdata = {5'd0, result.write_bytes, result.write_data, result.write_address,
                      result.new_stack_pointer, result.new_flags,
                      result.new_instr_pointer, result.new_code_segment};

endmodule
